### design/erm_pkg.sv
package erm_pkg;

  localparam int WINDOW     = 7;
  localparam int FRAC_BITS  = 8;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int MED_POS    = WINDOW / 2;

  localparam int WIDTH_W    = 16;
  localparam int COEF_W     = 16;
  localparam int CM_W       = 10;
  localparam int ALPHA_W    = 9;
  localparam int DIST_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int PROD_W     = WIDTH_W + COEF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int SHIFT      = 16 - FRAC_BITS;
  localparam int ROUND_HALF = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;

  localparam int EMA_P_W    = ALPHA_W + DIST_W;
  localparam int EMA_SUM_W  = EMA_P_W + 1;
  localparam int EMA_SHIFT  = 8;
  localparam int EMA_HALF   = 1 << (EMA_SHIFT - 1);

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  localparam logic [COEF_W-1:0]  COEF_RST  = COEF_W'(1124);
  localparam logic [CM_W-1:0]    MIN_RST   = CM_W'(20);
  localparam logic [CM_W-1:0]    MAX_RST   = CM_W'(400);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(77);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF,
    REG_MIN,
    REG_MAX,
    REG_ALPHA
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_MED,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic conv;
    logic check;
    logic med_step;
    logic ema_mul;
    logic ema_add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic full_after;
    logic med_hit;
    logic out_free;
  } stat_t;

endpackage

### design/erm_if.sv
interface erm_in_if;
  logic                          valid;
  logic                          ready;
  logic [erm_pkg::WIDTH_W-1:0]   echo_width_us;

  modport source (output valid, output echo_width_us, input ready);
  modport sink   (input valid, input echo_width_us, output ready);
endinterface

interface erm_out_if;
  logic                          valid;
  logic                          ready;
  logic [erm_pkg::DIST_W-1:0]    distance_q8;
  logic                          valid_res;
  logic                          filtered;

  modport source (output valid, output distance_q8, output valid_res, output filtered,
                  input ready);
  modport sink   (input valid, input distance_q8, input valid_res, input filtered,
                  output ready);
endinterface

### design/erm_ctrl.sv
module erm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  erm_pkg::stat_t stat,
  output erm_pkg::cmd_t  cmd
);
  import erm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = (stat.ok && stat.full_after) ? ST_MED : ST_DONE;
      end
      ST_MED: begin
        cmd.med_step = 1'b1;
        if (stat.med_hit) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.ema_mul = 1'b1;
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        cmd.ema_add = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/erm_dp.sv
module erm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [erm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [erm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [erm_pkg::WIDTH_W-1:0]     in_echo_width_us,
  input  erm_pkg::cmd_t                   cmd,
  output erm_pkg::stat_t                  stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [erm_pkg::DIST_W-1:0]      out_distance_q8,
  output logic                            out_valid_res,
  output logic                            out_filtered
);
  import erm_pkg::*;

  logic [COEF_W-1:0]  coef_r;
  logic [CM_W-1:0]    min_r;
  logic [CM_W-1:0]    max_r;
  logic [ALPHA_W-1:0] alpha_r;

  logic [WIDTH_W-1:0] width_r;
  logic [SUM_W-1:0]   raw_r;

  logic [DIST_W-1:0]  store_r [WINDOW];
  logic [IDX_W-1:0]   slot_r;
  logic               full_r;
  logic [DIST_W-1:0]  smooth_r;

  logic [IDX_W-1:0]   cand_r;
  logic [DIST_W-1:0]  med_r;
  logic [EMA_P_W-1:0] p1_r;
  logic [EMA_P_W-1:0] p2_r;

  logic [DIST_W-1:0]  res_dist_r;
  logic               res_valid_r;
  logic               res_filt_r;

  logic               out_valid_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_vres_r;
  logic               out_filt_r;

  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   raw_nxt;
  logic [SUM_W-1:0]   lo_bound;
  logic [SUM_W-1:0]   hi_bound;
  logic               ok;
  logic [DIST_W-1:0]  dist_val;
  logic               slot_last;

  logic [DIST_W-1:0]  cand_val;
  logic [CNT_W-1:0]   lt_cnt;
  logic [CNT_W-1:0]   le_cnt;
  logic               med_hit;

  logic [ALPHA_W-1:0]   a_eff;
  logic [ALPHA_W-1:0]   a_inv;
  logic [EMA_SUM_W-1:0] ema_sum;
  logic [EMA_SUM_W-EMA_SHIFT-1:0] ema_shr;
  logic [DIST_W-1:0]    smooth_nxt;

  always_comb begin
    prod     = PROD_W'(width_r) * PROD_W'(coef_r);
    raw_nxt  = (SUM_W'(prod) + SUM_W'(ROUND_HALF)) >> SHIFT;
    lo_bound = SUM_W'(min_r) << FRAC_BITS;
    hi_bound = SUM_W'(max_r) << FRAC_BITS;
    ok       = (width_r != '0) && (raw_r >= lo_bound) && (raw_r <= hi_bound);
    dist_val = (raw_r > SUM_W'(DIST_MAX)) ? DIST_MAX : raw_r[DIST_W-1:0];
    slot_last = (slot_r == IDX_W'(WINDOW - 1));
  end

  always_comb begin
    cand_val = store_r[cand_r];
    lt_cnt   = '0;
    le_cnt   = '0;
    for (int i = 0; i < WINDOW; i++) begin
      lt_cnt = lt_cnt + CNT_W'(store_r[i] <  cand_val);
      le_cnt = le_cnt + CNT_W'(store_r[i] <= cand_val);
    end
    med_hit = (lt_cnt <= CNT_W'(MED_POS)) && (le_cnt > CNT_W'(MED_POS));
  end

  always_comb begin
    a_eff      = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    a_inv      = ALPHA_ONE - a_eff;
    ema_sum    = EMA_SUM_W'(p1_r) + EMA_SUM_W'(p2_r) + EMA_SUM_W'(EMA_HALF);
    ema_shr    = ema_sum[EMA_SUM_W-1:EMA_SHIFT];
    smooth_nxt = (ema_shr > (EMA_SUM_W-EMA_SHIFT)'(DIST_MAX)) ? DIST_MAX
                                                              : ema_shr[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= COEF_RST;
      min_r   <= MIN_RST;
      max_r   <= MAX_RST;
      alpha_r <= ALPHA_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF:  coef_r  <= cfg_data[COEF_W-1:0];
        REG_MIN:   min_r   <= cfg_data[CM_W-1:0];
        REG_MAX:   max_r   <= cfg_data[CM_W-1:0];
        REG_ALPHA: alpha_r <= cfg_data[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      full_r   <= 1'b0;
      smooth_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cmd.check && ok) begin
        store_r[slot_r] <= dist_val;
        slot_r          <= slot_last ? '0 : slot_r + IDX_W'(1);
        if (slot_last) begin
          full_r <= 1'b1;
        end
      end
      if (cmd.ema_add) begin
        smooth_r <= smooth_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      width_r <= in_echo_width_us;
    end
    if (cmd.conv) begin
      raw_r <= raw_nxt;
    end
    if (cmd.check) begin
      cand_r      <= '0;
      res_dist_r  <= ok ? dist_val : '0;
      res_valid_r <= ok;
      res_filt_r  <= 1'b0;
    end
    if (cmd.med_step) begin
      if (med_hit) begin
        med_r <= cand_val;
      end else begin
        cand_r <= cand_r + IDX_W'(1);
      end
    end
    if (cmd.ema_mul) begin
      p1_r <= EMA_P_W'(a_eff) * EMA_P_W'(med_r);
      p2_r <= EMA_P_W'(a_inv) * EMA_P_W'(smooth_r);
    end
    if (cmd.ema_add) begin
      res_dist_r  <= smooth_nxt;
      res_valid_r <= 1'b1;
      res_filt_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_dist_r <= res_dist_r;
      out_vres_r <= res_valid_r;
      out_filt_r <= res_filt_r;
    end
  end

  assign stat.ok         = ok;
  assign stat.full_after = full_r || slot_last;
  assign stat.med_hit    = med_hit;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_distance_q8 = out_dist_r;
  assign out_valid_res   = out_vres_r;
  assign out_filtered    = out_filt_r;

endmodule

### design/echo_range_median_ema_filter.sv
// Ultrasonic echo range filter. Each item carries one echo width in microseconds
// (0 = no echo) and gives exactly one result: the distance in Q8 centimetres, a
// valid flag and a filtered flag. Widths converting outside [min, max] cm give an
// all-zero result and leave the window untouched. During the first six valid
// readings the raw distance is returned; from the seventh on the median of the
// seven-entry window drives an EMA (alpha in Q8), and the EMA value is returned.
// One item is in work at a time: an invalid or fill-phase item passes through
// conversion and range check to the output register; a filtered item also goes
// through the median rank search, which tests one window entry per cycle, and
// the EMA multiply and add steps before it reaches the output register. A
// finished result waits until the output register is free or being read. The
// next item is taken while a result waits in the output register.
// Configuration writes are meant for idle periods.
module echo_range_median_ema_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [erm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [erm_pkg::CFG_DATA_W-1:0]  cfg_data,
  erm_in_if.sink                          in_ch,
  erm_out_if.source                       out_ch
);
  import erm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  erm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  erm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_echo_width_us (in_ch.echo_width_us),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_distance_q8  (out_ch.distance_q8),
    .out_valid_res    (out_ch.valid_res),
    .out_filtered     (out_ch.filtered)
  );

endmodule

### design/erm_chk.sv
module erm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [erm_pkg::DIST_W-1:0]  out_distance_q8,
  input logic                        out_valid_res,
  input logic                        out_filtered
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_q8))
    else $error("result dropped or changed while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_distance_q8 == '0 && !out_filtered)
    else $error("invalid result carries data");

  a_filt_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_filtered |-> out_valid_res)
    else $error("filtered result marked invalid");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not quiet after reset");

endmodule

bind echo_range_median_ema_filter erm_chk u_erm_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_distance_q8 (out_ch.distance_q8),
  .out_valid_res   (out_ch.valid_res),
  .out_filtered    (out_ch.filtered)
);
